[src/srt_pkg.sv]
package srt_pkg;

	// Status codes carried by every result item.
	typedef enum logic [2:0] {
		STATUS_INSERTED = 3'd0,
		STATUS_BAD_DAY  = 3'd1,
		STATUS_FULL     = 3'd2,
		STATUS_ENTRY    = 3'd3,
		STATUS_EMPTY    = 3'd4
	} status_t;

	// Command modes.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DUMP   = 1'b1;

	// Input item.
	typedef struct packed {
		logic        mode;
		logic [4:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [31:0] tag;
	} cmd_t;

	// Result item.
	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [4:0]  out_day;
		logic [6:0]  out_hour;
		logic [6:0]  out_minute;
		logic [31:0] out_tag;
		logic        last;
	} result_t;

	// One stored table entry, 51 bits.
	typedef struct packed {
		logic [4:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [31:0] tag;
	} entry_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_DMP_RD,
		S_DMP_OUT
	} state_t;

	// Sort key: day most significant, then hour, then minute.
	function automatic logic [18:0] entry_key(input entry_t e);
		return {e.day, e.hour, e.minute};
	endfunction

endpackage

[src/srt_mem.sv]
module srt_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  srt_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output srt_pkg::entry_t  rdata
);
	import srt_pkg::*;

	entry_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/sorted_reminder_table_unit.sv]
// Sorted reminder table: keeps up to CAPACITY entries in ascending order of
// (day, hour, minute) in a single-port-read, single-port-write memory.
// An item is accepted on a rising edge with start high and busy low; cmd
// carries the mode, key and tag. Results appear on result for one cycle,
// marked by valid, and the receiver must take them as they come.
// An insert gives one result. A full table or a day of zero answers in
// the cycle after the item. A good insert walks from the tail of the table
// toward the head, one memory read then one compare-and-write per entry
// that moves down, and its result is registered; equal keys place the new
// entry first. A dump reads each entry and then emits it, so a table of
// n entries gives n results, the last one marked with last; an empty
// table answers a single empty status. The registered memory read sets
// the read-then-use step of both loops. busy is high from acceptance of
// an insert walk or a dump until the last result has been registered;
// items answered at once leave busy low. Reset clears the entry count and
// the sequencer; the memory holds no reset value and needs no clearing
// pass, since only filled slots are read.
module sorted_reminder_table_unit #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  srt_pkg::cmd_t    cmd,
	output logic             valid,
	output srt_pkg::result_t result
);
	import srt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t         state_q, state_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic [CW-1:0]  count_q, count_d;
	cmd_t           cmd_q;
	logic           valid_q, valid_d;
	result_t        result_q, result_d;

	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	entry_t         mem_wdata, mem_rdata;
	entry_t         new_entry;
	logic           accept;
	logic           full;
	logic           dump_last;

	assign accept    = start && (state_q == S_IDLE);
	assign full      = (count_q == CW'(CAPACITY));
	assign new_entry = '{day: cmd_q.day, hour: cmd_q.hour, minute: cmd_q.minute,
		tag: cmd_q.tag};
	assign dump_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// Entry storage.
	srt_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			valid_q <= valid_d;
		end
	end

	// Index, captured item and result payload.
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			cmd_q <= cmd;
		end
		if (valid_d) begin
			result_q <= result_d;
		end
	end

	// Next state, memory control and result formation.
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		valid_d   = 1'b0;
		result_d  = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = new_entry;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					priority if (cmd.mode == MODE_DUMP) begin
						if (count_q == '0) begin
							valid_d         = 1'b1;
							result_d.status = STATUS_EMPTY;
							result_d.last   = 1'b1;
						end else begin
							idx_d   = '0;
							state_d = S_DMP_RD;
						end
					end else if (full) begin
						valid_d         = 1'b1;
						result_d.status = STATUS_FULL;
						result_d.last   = 1'b1;
					end else if (cmd.day == 5'd0) begin
						valid_d         = 1'b1;
						result_d.status = STATUS_BAD_DAY;
						result_d.last   = 1'b1;
					end else begin
						// Walk starts just past the current tail.
						idx_d   = count_q[AW-1:0];
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				if (idx_q == '0) begin
					// Reached the head: the new entry goes into slot zero.
					mem_we          = 1'b1;
					count_d         = count_q + CW'(1);
					valid_d         = 1'b1;
					result_d.status = STATUS_INSERTED;
					result_d.slot   = 6'(idx_q);
					result_d.last   = 1'b1;
					state_d         = S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_q - AW'(1);
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (entry_key(new_entry) <= entry_key(mem_rdata)) begin
					// Stored entry is not smaller: move it down one slot.
					mem_wdata = mem_rdata;
					idx_d     = idx_q - AW'(1);
					state_d   = S_INS_RD;
				end else begin
					count_d         = count_q + CW'(1);
					valid_d         = 1'b1;
					result_d.status = STATUS_INSERTED;
					result_d.slot   = 6'(idx_q);
					result_d.last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_DMP_RD: begin
				mem_re  = 1'b1;
				state_d = S_DMP_OUT;
			end
			S_DMP_OUT: begin
				valid_d             = 1'b1;
				result_d.status     = STATUS_ENTRY;
				result_d.slot       = 6'(idx_q);
				result_d.out_day    = mem_rdata.day;
				result_d.out_hour   = mem_rdata.hour;
				result_d.out_minute = mem_rdata.minute;
				result_d.out_tag    = mem_rdata.tag;
				result_d.last       = dump_last;
				if (dump_last) begin
					state_d = S_IDLE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = S_DMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = result_q;

endmodule

[test/tb_sorted_reminder_table_unit.sv]
module tb_sorted_reminder_table_unit;
	import srt_pkg::*;

	localparam int TABLE_SIZE   = 32;
	localparam int RANDOM_ITEMS = 140;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int CALM_TAIL    = 30;

	// One row of the directed stimulus; a typed row carries its own answer.
	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    valid;
	result_t result;

	sorted_reminder_table_unit #(
		.CAPACITY(TABLE_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.valid(valid),
		.result(result)
	);

	always #1 clk = ~clk;

	// Shadow copy of the reminder table and the results still owed by the block.
	entry_t    shadow_entries [TABLE_SIZE];
	int        shadow_fill;
	result_t   owed_results [$];
	result_t   item_results [$];
	int        mismatches;
	stim_row_t opening_rows [$];
	stim_row_t closing_rows [$];
	bit        idle_phase;

	function automatic result_t status_only(input status_t s, input logic [5:0] slot);
		result_t r;
		r = '0;
		r.status = s;
		r.slot = slot;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic cmd_t make_cmd(input logic m, input logic [4:0] d, input logic [6:0] h,
			input logic [6:0] mi, input logic [31:0] t);
		cmd_t c;
		c.mode = m;
		c.day = d;
		c.hour = h;
		c.minute = mi;
		c.tag = t;
		return c;
	endfunction

	function automatic stim_row_t make_row(input cmd_t c, input bit typed, input result_t want);
		stim_row_t r;
		r.c = c;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Apply one accepted item to the shadow table and collect the results it causes.
	function automatic void predict_table(input cmd_t c);
		result_t     r;
		logic [18:0] new_key;
		int          pos;
		item_results.delete();
		if (c.mode == MODE_DUMP) begin
			if (shadow_fill == 0) begin
				item_results.push_back(status_only(STATUS_EMPTY, '0));
			end else begin
				for (int i = 0; i < shadow_fill; i++) begin
					r = '0;
					r.status = STATUS_ENTRY;
					r.slot = i[5:0];
					r.out_day = shadow_entries[i].day;
					r.out_hour = shadow_entries[i].hour;
					r.out_minute = shadow_entries[i].minute;
					r.out_tag = shadow_entries[i].tag;
					r.last = (i == shadow_fill - 1);
					item_results.push_back(r);
				end
			end
		end else if (shadow_fill == TABLE_SIZE) begin
			item_results.push_back(status_only(STATUS_FULL, '0));
		end else if (c.day == '0) begin
			item_results.push_back(status_only(STATUS_BAD_DAY, '0));
		end else begin
			// The new entry goes ahead of the first entry whose key is not smaller.
			new_key = {c.day, c.hour, c.minute};
			pos = shadow_fill;
			for (int i = shadow_fill - 1; i >= 0; i--) begin
				if (new_key <= {shadow_entries[i].day, shadow_entries[i].hour,
						shadow_entries[i].minute})
					pos = i;
			end
			for (int i = shadow_fill; i > pos; i--)
				shadow_entries[i] = shadow_entries[i - 1];
			shadow_entries[pos] = {c.day, c.hour, c.minute, c.tag};
			shadow_fill++;
			item_results.push_back(status_only(STATUS_INSERTED, pos[5:0]));
		end
	endfunction

	// Random item; a third of inserts use a crowded key range so equal keys are common.
	function automatic cmd_t random_cmd(input int insert_pct);
		cmd_t c;
		c.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_DUMP;
		c.tag = $urandom;
		case ($urandom_range(0, 8))
			0: begin
				c.day = '0;
				c.hour = 7'($urandom_range(0, 127));
				c.minute = 7'($urandom_range(0, 127));
			end
			1, 2, 3: begin
				c.day = 5'($urandom_range(1, 2));
				c.hour = 7'($urandom_range(98, 100));
				c.minute = 7'($urandom_range(0, 1));
			end
			default: begin
				c.day = 5'($urandom_range(1, 31));
				c.hour = 7'($urandom_range(0, 127));
				c.minute = 7'($urandom_range(0, 127));
			end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected st=%0d slot=%0d d=%0d h=%0d m=%0d ",
				what, want.status, want.slot, want.out_day, want.out_hour,
				"tag=%h last=%b, ", want.out_minute, want.out_tag, want.last,
				"got st=%0d slot=%0d d=%0d h=%0d m=%0d tag=%h last=%b",
				got.status, got.slot, got.out_day, got.out_hour,
				got.out_minute, got.out_tag, got.last);
	endtask

	// Compare one result with the oldest one owed, field by field.
	task automatic check_result(input result_t got);
		result_t want;
		string   bad;
		if (owed_results.size() == 0) begin
			report_mismatch("no result was due", '0, got);
			return;
		end
		want = owed_results.pop_front();
		bad = "";
		if (got.status !== want.status)
			bad = {bad, " status"};
		if (got.slot !== want.slot)
			bad = {bad, " slot"};
		if (got.out_day !== want.out_day)
			bad = {bad, " out_day"};
		if (got.out_hour !== want.out_hour)
			bad = {bad, " out_hour"};
		if (got.out_minute !== want.out_minute)
			bad = {bad, " out_minute"};
		if (got.out_tag !== want.out_tag)
			bad = {bad, " out_tag"};
		if (got.last !== want.last)
			bad = {bad, " last"};
		if (bad != "")
			report_mismatch({"wrong", bad}, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && valid === 1'b1)
			check_result(result);
	end

	// Present one item from a falling edge and hold it until the block takes it.
	task automatic drive_item(input cmd_t c, input bit typed, input result_t want);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		predict_table(c);
		if (typed) begin
			owed_results.push_back(want);
		end else begin
			foreach (item_results[i])
				owed_results.push_back(item_results[i]);
		end
		@(negedge clk);
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Idle bursts come in phases, so some stretches run back to back.
	task automatic maybe_idle(input int k);
		if (k % 16 == 0)
			idle_phase = ($urandom_range(0, 3) != 0);
		if (idle_phase && $urandom_range(0, 2) == 0)
			hold_off($urandom_range(1, 17));
	endtask

	// Stall watchdog: ends the run when nothing moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (valid === 1'b1 || (start && busy === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		mismatches = 0;
		shadow_fill = 0;
		idle_phase = 1'b0;

		// Opening rows: empty dump, bad day, key extremes, equal keys, hour and minute above 99.
		opening_rows.push_back(make_row(make_cmd(MODE_DUMP, 5'd0, 7'd0, 7'd0, 32'h0), 1'b1,
			status_only(STATUS_EMPTY, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd0, 7'd127, 7'd127,
			32'hFFFF_FFFF), 1'b1, status_only(STATUS_BAD_DAY, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd31, 7'd127, 7'd127,
			32'hFFFF_FFFF), 1'b1, status_only(STATUS_INSERTED, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd1, 7'd0, 7'd0, 32'h0), 1'b1,
			status_only(STATUS_INSERTED, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd1, 7'd0, 7'd0, 32'h1), 1'b1,
			status_only(STATUS_INSERTED, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_DUMP, 5'd0, 7'd0, 7'd0, 32'h0), 1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd31, 7'd127, 7'd127, 32'h2),
			1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd15, 7'd100, 7'd50,
			32'hA5A5_A5A5), 1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd15, 7'd99, 7'd99,
			32'h5A5A_5A5A), 1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd15, 7'd99, 7'd100,
			32'h0F0F_0F0F), 1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd31, 7'd0, 7'd0, 32'h8000_0000),
			1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd0, 7'd0, 7'd0, 32'h0), 1'b1,
			status_only(STATUS_BAD_DAY, 6'd0)));
		opening_rows.push_back(make_row(make_cmd(MODE_DUMP, 5'd31, 7'd127, 7'd127,
			32'hFFFF_FFFF), 1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd16, 7'd64, 7'd1, 32'h1234_5678),
			1'b0, '0));
		opening_rows.push_back(make_row(make_cmd(MODE_DUMP, 5'd0, 7'd0, 7'd0, 32'h0), 1'b0, '0));

		// Closing rows run on a full table: the full check wins over a bad day.
		closing_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd0, 7'd0, 7'd0, 32'h0), 1'b1,
			status_only(STATUS_FULL, 6'd0)));
		closing_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd31, 7'd127, 7'd127,
			32'hFFFF_FFFF), 1'b1, status_only(STATUS_FULL, 6'd0)));
		closing_rows.push_back(make_row(make_cmd(MODE_INSERT, 5'd1, 7'd0, 7'd0, 32'h0), 1'b1,
			status_only(STATUS_FULL, 6'd0)));
		closing_rows.push_back(make_row(make_cmd(MODE_DUMP, 5'd0, 7'd0, 7'd0, 32'h0), 1'b0, '0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			drive_item(opening_rows[i].c, opening_rows[i].typed, opening_rows[i].want);
			maybe_idle(i);
		end

		// Random items; halfway through the sender waits for the block to drain.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			drive_item(random_cmd(60), 1'b0, '0);
			if (k == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				@(negedge clk);
				while (owed_results.size() != 0)
					@(negedge clk);
			end else if (k < RANDOM_ITEMS - CALM_TAIL) begin
				maybe_idle(k);
			end
		end

		// Top the table up so the closing rows see it full.
		while (shadow_fill < TABLE_SIZE)
			drive_item(make_cmd(MODE_INSERT, 5'($urandom_range(1, 31)),
				7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), $urandom),
				1'b0, '0);

		foreach (closing_rows[i])
			drive_item(closing_rows[i].c, closing_rows[i].typed, closing_rows[i].want);

		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
